@@ design/swms_pkg.sv @@
// ----------------------------------------------------------------------------
// swms_pkg
// Shared constants, types and helper functions for the sliding window
// minimum block.
// ----------------------------------------------------------------------------
package swms_pkg;

    localparam int MAX_WINDOW = 1024;
    localparam int AW         = $clog2(MAX_WINDOW);
    localparam int PW         = $clog2(MAX_WINDOW + 1);
    localparam int SW         = 32;
    localparam int CW         = 11;
    localparam int OW         = 64;
    localparam int EW         = SW + PW;
    localparam int QD         = 2;
    localparam int QAW        = $clog2(QD);

    typedef struct packed {
        logic signed [SW-1:0] sample;
        logic                 restart;
        logic [PW-1:0]        win;
    } t_item;

    function automatic logic [PW-1:0] eff_window(input logic [CW-1:0] len);
        logic [PW-1:0] w;
        if (len == '0) begin
            w = PW'(1);
        end else if (32'(len) > 32'(MAX_WINDOW)) begin
            w = PW'(MAX_WINDOW);
        end else begin
            w = PW'(len);
        end
        return w;
    endfunction

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] base,
                                           input logic [PW-1:0] off);
        logic [PW:0] s;
        s = (PW+1)'(base) + (PW+1)'(off);
        if (s >= (PW+1)'(MAX_WINDOW)) begin
            s = s - (PW+1)'(MAX_WINDOW);
        end
        return AW'(s);
    endfunction

endpackage

@@ design/swms_front.sv @@
// ----------------------------------------------------------------------------
// swms_front
// Holds the window length register, tags each request with its effective
// window and buffers requests in a short queue ahead of the deque engine.
// ----------------------------------------------------------------------------
module swms_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [swms_pkg::CW-1:0]       i_cfg_wdata,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [swms_pkg::SW-1:0] i_sample,
    input  logic                          i_restart,
    output logic                          o_item_valid,
    output swms_pkg::t_item               o_item,
    input  logic                          i_item_take
);

    logic [swms_pkg::CW-1:0]  r_window_len;
    swms_pkg::t_item          r_q [swms_pkg::QD];
    logic [swms_pkg::QAW-1:0] r_wr_ptr;
    logic [swms_pkg::QAW-1:0] r_rd_ptr;
    logic [swms_pkg::QAW:0]   r_fill;
    logic                     push;
    logic                     pop;
    swms_pkg::t_item          n_item;

    assign o_stall      = (r_fill == (swms_pkg::QAW+1)'(swms_pkg::QD));
    assign o_item_valid = (r_fill != '0);
    assign o_item       = r_q[r_rd_ptr];
    assign push         = i_valid && !o_stall;
    assign pop          = o_item_valid && i_item_take;

    always_comb begin
        n_item.sample  = i_sample;
        n_item.restart = i_restart;
        n_item.win     = swms_pkg::eff_window(r_window_len);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_len <= swms_pkg::CW'(1);
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fill       <= '0;
        end else begin
            if (i_cfg_we) begin
                r_window_len <= i_cfg_wdata;
            end
            if (push) begin
                r_wr_ptr <= r_wr_ptr + swms_pkg::QAW'(1);
            end
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + swms_pkg::QAW'(1);
            end
            if (push && !pop) begin
                r_fill <= r_fill + (swms_pkg::QAW+1)'(1);
            end else if (pop && !push) begin
                r_fill <= r_fill - (swms_pkg::QAW+1)'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wr_ptr] <= n_item;
        end
    end

endmodule

@@ design/swms_back.sv @@
// ----------------------------------------------------------------------------
// swms_back
// Deque engine: retires stale head entries, drops larger tail entries,
// appends the sample and forms the window minimum and saturating sum.
// ----------------------------------------------------------------------------
module swms_back (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_item_valid,
    input  swms_pkg::t_item                i_item,
    output logic                           o_item_take,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_window_full,
    output logic signed [swms_pkg::SW-1:0] o_window_min,
    output logic signed [swms_pkg::OW-1:0] o_running_sum
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RET_RD,
        S_RET_CHK,
        S_POP_RD,
        S_POP_CHK,
        S_APPEND,
        S_MIN_RD,
        S_MIN_CHK
    } t_state;

    t_state                          r_state;
    logic [swms_pkg::AW-1:0]         r_head;
    logic [swms_pkg::PW-1:0]         r_count;
    logic [swms_pkg::PW-1:0]         r_pos;
    logic [swms_pkg::PW-1:0]         r_filled;
    logic signed [swms_pkg::OW-1:0]  r_total;
    logic signed [swms_pkg::SW-1:0]  r_x;
    logic [swms_pkg::PW-1:0]         r_win;
    logic [swms_pkg::EW-1:0]         r_mem [swms_pkg::MAX_WINDOW];
    logic [swms_pkg::EW-1:0]         r_rd;
    logic                            r_out_valid;
    logic                            r_out_full;
    logic signed [swms_pkg::SW-1:0]  r_out_min;
    logic signed [swms_pkg::OW-1:0]  r_out_sum;

    logic [swms_pkg::AW-1:0]         rd_addr;
    logic [swms_pkg::AW-1:0]         wr_addr;
    logic                            wr_en;
    logic signed [swms_pkg::SW-1:0]  rd_val;
    logic [swms_pkg::PW-1:0]         rd_pos;
    logic [swms_pkg::PW-1:0]         age;
    logic                            full;
    logic                            out_free;
    logic                            out_load;
    logic signed [swms_pkg::OW-1:0]  min_ext;
    logic signed [swms_pkg::OW-1:0]  raw_sum;
    logic signed [swms_pkg::OW-1:0]  n_total;

    assign rd_val   = $signed(r_rd[swms_pkg::EW-1:swms_pkg::PW]);
    assign rd_pos   = r_rd[swms_pkg::PW-1:0];
    assign age      = r_pos - rd_pos;
    assign full     = (r_filled >= r_win);
    assign out_free = !r_out_valid || !i_stall;
    assign out_load = (r_state == S_MIN_CHK) && out_free;
    assign min_ext  = swms_pkg::OW'(rd_val);
    assign raw_sum  = r_total + min_ext;
    assign wr_en    = (r_state == S_APPEND);
    assign wr_addr  = swms_pkg::slot(r_head, r_count);

    assign o_item_take   = (r_state == S_IDLE) && i_item_valid;
    assign o_valid       = r_out_valid;
    assign o_window_full = r_out_full;
    assign o_window_min  = r_out_min;
    assign o_running_sum = r_out_sum;

    always_comb begin
        case (r_state)
            S_POP_RD: rd_addr = swms_pkg::slot(r_head, r_count - swms_pkg::PW'(1));
            default:  rd_addr = r_head;
        endcase
    end

    always_comb begin
        if ((r_total[swms_pkg::OW-1] == min_ext[swms_pkg::OW-1]) &&
            (raw_sum[swms_pkg::OW-1] != r_total[swms_pkg::OW-1])) begin
            n_total = r_total[swms_pkg::OW-1] ? {1'b1, {(swms_pkg::OW-1){1'b0}}}
                                              : {1'b0, {(swms_pkg::OW-1){1'b1}}};
        end else begin
            n_total = raw_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= {r_x, r_pos};
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_count     <= '0;
            r_pos       <= '0;
            r_filled    <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && !out_load) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_item_valid) begin
                        r_x   <= i_item.sample;
                        r_win <= i_item.win;
                        if (i_item.restart) begin
                            r_head   <= '0;
                            r_count  <= '0;
                            r_pos    <= '0;
                            r_filled <= '0;
                            r_total  <= '0;
                        end
                        r_state <= S_RET_RD;
                    end
                end
                S_RET_RD: begin
                    r_state <= (r_count == '0) ? S_POP_RD : S_RET_CHK;
                end
                S_RET_CHK: begin
                    if (age >= r_win) begin
                        r_head  <= swms_pkg::slot(r_head, swms_pkg::PW'(1));
                        r_count <= r_count - swms_pkg::PW'(1);
                        r_state <= S_RET_RD;
                    end else begin
                        r_state <= S_POP_RD;
                    end
                end
                S_POP_RD: begin
                    r_state <= (r_count == '0) ? S_APPEND : S_POP_CHK;
                end
                S_POP_CHK: begin
                    if (rd_val > r_x) begin
                        r_count <= r_count - swms_pkg::PW'(1);
                        r_state <= S_POP_RD;
                    end else begin
                        r_state <= S_APPEND;
                    end
                end
                S_APPEND: begin
                    r_count <= r_count + swms_pkg::PW'(1);
                    r_pos   <= r_pos + swms_pkg::PW'(1);
                    if (r_filled != swms_pkg::PW'(swms_pkg::MAX_WINDOW)) begin
                        r_filled <= r_filled + swms_pkg::PW'(1);
                    end
                    r_state <= S_MIN_RD;
                end
                S_MIN_RD: begin
                    r_state <= S_MIN_CHK;
                end
                S_MIN_CHK: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_out_full  <= full;
                        r_out_min   <= full ? rd_val : '0;
                        r_out_sum   <= full ? n_total : r_total;
                        if (full) begin
                            r_total <= n_total;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= swms_pkg::PW'(swms_pkg::MAX_WINDOW))
        else $error("deque count above capacity");

    a_filled_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled <= swms_pkg::PW'(swms_pkg::MAX_WINDOW))
        else $error("filled count above capacity");

    a_append_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPEND) |=> (r_count != '0))
        else $error("deque empty after append");

    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_MIN_CHK))
        else $error("result loaded outside the minimum stage");

endmodule

@@ design/sliding_window_minimum_sum.sv @@
// ----------------------------------------------------------------------------
// sliding_window_minimum_sum
// Streaming minimum over the last window_len samples, with a saturating
// 64-bit running sum of the minima.
// ----------------------------------------------------------------------------
// Each request walks the deque in order: it retires stale entries from the
// head, drops larger entries from the tail, appends the sample and reads the
// head as the minimum; loading the result waits while the result register is
// held by a stall. A new request is taken only once the last one is done.
// The engine's pace is set by the single read port of the 1024-entry deque memory,
// which the engine walks one entry per read. A two-entry request queue sits
// in front of the engine, and one result register behind it.
// ----------------------------------------------------------------------------
module sliding_window_minimum_sum (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [swms_pkg::CW-1:0]        i_cfg_wdata,
    input  logic                           i_valid,
    output logic                           o_stall,
    input  logic signed [swms_pkg::SW-1:0] i_sample,
    input  logic                           i_restart,
    output logic                           o_valid,
    input  logic                           i_stall,
    output logic                           o_window_full,
    output logic signed [swms_pkg::SW-1:0] o_window_min,
    output logic signed [swms_pkg::OW-1:0] o_running_sum
);

    logic            item_valid;
    swms_pkg::t_item item;
    logic            item_take;

    swms_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_sample     (i_sample),
        .i_restart    (i_restart),
        .o_item_valid (item_valid),
        .o_item       (item),
        .i_item_take  (item_take)
    );

    swms_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_item_valid  (item_valid),
        .i_item        (item),
        .o_item_take   (item_take),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_window_full (o_window_full),
        .o_window_min  (o_window_min),
        .o_running_sum (o_running_sum)
    );

endmodule
